@@ src/tvt_pkg.sv @@
// Package with shared types, constants and tables for the twist vertex transform.
package tvt_pkg;

  localparam int CoordW = 17;
  localparam int RateW = 20;
  localparam int SumW = 35;
  localparam int DistW = 18;
  localparam int PhaseW = 32;
  localparam int CordW = 34;
  localparam int MaxStages = 32;
  localparam int TermW = 52;

  localparam logic [29:0] TurnScale = 30'd683565276;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CoordW-1:0] CoordMax = 17'sd65535;
  localparam logic signed [CoordW-1:0] CoordMin = -17'sd65536;

  typedef enum logic [1:0] {
    QuadZero  = 2'd0,
    QuadOne   = 2'd1,
    QuadTwo   = 2'd2,
    QuadThree = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [CordW-1:0] cx;
    logic signed [CordW-1:0] sy;
    logic signed [PhaseW:0]  resid;
  } cordic_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    quad_e                    quad;
  } vtx_t;

  function automatic logic [PhaseW-1:0] atan_turn(input int unsigned idx);
    logic [PhaseW-1:0] tab [MaxStages];
    tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
            32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
            32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
            32'd166886, 32'd83443, 32'd41722, 32'd20861,
            32'd10430, 32'd5215, 32'd2608, 32'd1304,
            32'd652, 32'd326, 32'd163, 32'd81,
            32'd41, 32'd20, 32'd10, 32'd5,
            32'd3, 32'd1, 32'd1, 32'd0};
    return tab[idx[4:0]];
  endfunction

endpackage

@@ src/tvt_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
module tvt_sqrt_cell import tvt_pkg::*; (
  input  logic              clk_i,
  input  logic [SumW:0]     rem_i,
  input  logic [DistW-1:0]  root_i,
  input  logic [2*SumW-1:0] rad_i,
  input  vtx_t              vtx_i,
  input  logic              rev_i,
  output logic [SumW:0]     rem_o,
  output logic [DistW-1:0]  root_o,
  output logic [2*SumW-1:0] rad_o,
  output vtx_t              vtx_o,
  output logic              rev_o
);

  logic [SumW:0] rem_sh;
  logic [SumW:0] trial;

  assign rem_sh = {rem_i[SumW-2:0], rad_i[2*SumW-1 -: 2]};
  assign trial = {{(SumW+1-DistW-2){1'b0}}, root_i, 2'b01};

  always_ff @(posedge clk_i) begin
    if (rem_sh >= trial) begin
      rem_o <= rem_sh - trial;
      root_o <= {root_i[DistW-2:0], 1'b1};
    end else begin
      rem_o <= rem_sh;
      root_o <= {root_i[DistW-2:0], 1'b0};
    end
    rad_o <= {rad_i[2*SumW-3:0], 2'b00};
    vtx_o <= vtx_i;
    rev_o <= rev_i;
  end

endmodule

@@ src/tvt_cordic_cell.sv @@
// One rotation step of the CORDIC chain that carries the vertex along.
module tvt_cordic_cell import tvt_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic    clk_i,
  input  cordic_t cor_i,
  input  vtx_t    vtx_i,
  output cordic_t cor_o,
  output vtx_t    vtx_o
);

  logic signed [CordW-1:0] dx;
  logic signed [CordW-1:0] dy;
  logic signed [PhaseW:0]  ang;

  assign dx = cor_i.sy >>> Step;
  assign dy = cor_i.cx >>> Step;
  assign ang = $signed({1'b0, atan_turn(Step)});

  always_ff @(posedge clk_i) begin
    if (!cor_i.resid[PhaseW]) begin
      cor_o.cx <= cor_i.cx - dx;
      cor_o.sy <= cor_i.sy + dy;
      cor_o.resid <= cor_i.resid - ang;
    end else begin
      cor_o.cx <= cor_i.cx + dx;
      cor_o.sy <= cor_i.sy - dy;
      cor_o.resid <= cor_i.resid + ang;
    end
    vtx_o <= vtx_i;
  end

endmodule

@@ src/twist_vertex_transform.sv @@
// Twist vertex transform top level: sqrt chain, phase stages, CORDIC chain, output rotation.
// The CORDIC chain uses ROTATION_STAGES rotation stages (at most 32 stages).
// Throughput: one vertex per clock cycle; busy_o is always low.
// The receiver cannot stall; each result shows for one cycle with valid_o.
// Reset clears the twist rate and all valid flags; data registers are not reset.
module twist_vertex_transform import tvt_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 14,
  parameter int unsigned ROTATION_STAGES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [CoordW-1:0] x_coord_i,
  input  logic signed [CoordW-1:0] y_coord_i,
  input  logic                     reverse_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [RateW-1:0]         cfg_data_i,
  output logic                     valid_o,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o
);

  localparam int unsigned NCor = (ROTATION_STAGES > MaxStages) ? MaxStages : ROTATION_STAGES;
  localparam int unsigned NSq = DistW;
  localparam int unsigned Lat = NSq + 3 + NCor + 3;
  localparam int unsigned Shift = 16 + COORD_FRAC_BITS;

  logic [RateW-1:0] rate_q;
  logic [Lat-1:0]   vld_q;

  assign busy_o = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i) rate_q <= cfg_data_i;
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end

  // Square root chain.
  logic [SumW:0]     rem_w  [NSq+1];
  logic [DistW-1:0]  root_w [NSq+1];
  logic [2*SumW-1:0] rad_w  [NSq+1];
  vtx_t              sv_w   [NSq+1];
  logic              rv_w   [NSq+1];
  logic [SumW-1:0]   sumsq;

  assign sumsq = SumW'(34'($signed(x_coord_i) * $signed(x_coord_i)))
               + SumW'(34'($signed(y_coord_i) * $signed(y_coord_i)));
  assign rem_w[0] = '0;
  assign root_w[0] = '0;
  assign rad_w[0] = {1'b0, sumsq, {(SumW-1){1'b0}}};
  assign sv_w[0] = '{x: x_coord_i, y: y_coord_i, quad: QuadZero};
  assign rv_w[0] = reverse_i;

  for (genvar g = 0; g < NSq; g++) begin : g_sq
    tvt_sqrt_cell u_cell (
      .clk_i, .rem_i(rem_w[g]), .root_i(root_w[g]), .rad_i(rad_w[g]),
      .vtx_i(sv_w[g]), .rev_i(rv_w[g]),
      .rem_o(rem_w[g+1]), .root_o(root_w[g+1]), .rad_o(rad_w[g+1]),
      .vtx_o(sv_w[g+1]), .rev_o(rv_w[g+1])
    );
  end

  // Phase: P = rate * d, then P * TurnScale >> Shift, split in two products.
  logic [37:0]  p_q;
  vtx_t         p1v_q;
  logic         p1r_q;
  logic [67:0]  plo_q, phi_q;
  vtx_t         p2v_q;
  logic         p2r_q;
  logic [PhaseW-1:0] ph;
  logic [PhaseW-1:0] phs;
  logic [1:0]   qd;
  logic [PhaseW-1:0] ur;
  logic [71:0]  pfull;
  cordic_t      c_w [NCor+1];
  vtx_t         cv_w [NCor+1];
  cordic_t      c0_q;
  vtx_t         c0v_q;

  assign pfull = 72'(plo_q) + (72'(phi_q) << 19);
  assign ph = pfull[Shift +: PhaseW];
  assign phs = p2r_q ? (PhaseW'(0) - ph) : ph;
  assign qd = 2'((phs + 32'h2000_0000) >> 30);
  assign ur = phs - {qd, 30'd0};

  always_ff @(posedge clk_i) begin
    p_q <= 38'(rate_q * root_w[NSq]);
    p1v_q <= sv_w[NSq];
    p1r_q <= rv_w[NSq];
    plo_q <= 68'(p_q[18:0] * TurnScale);
    phi_q <= 68'(p_q[37:19] * TurnScale);
    p2v_q <= p1v_q;
    p2r_q <= p1r_q;
    c0_q <= '{cx: CordicGain, sy: '0, resid: $signed({ur[PhaseW-1], ur})};
    c0v_q <= '{x: p2v_q.x, y: p2v_q.y, quad: quad_e'(qd)};
  end

  assign c_w[0] = c0_q;
  assign cv_w[0] = c0v_q;

  for (genvar g = 0; g < NCor; g++) begin : g_cor
    tvt_cordic_cell #(.Step(g)) u_cell (
      .clk_i, .cor_i(c_w[g]), .vtx_i(cv_w[g]), .cor_o(c_w[g+1]), .vtx_o(cv_w[g+1])
    );
  end

  // Quadrant fix, products, round and saturate.
  logic signed [CordW-1:0] cc, ss;
  logic signed [TermW-1:0] cx_q, sy_q, sx_q, cy_q;
  logic signed [TermW-1:0] ox_q, oy_q;
  logic signed [TermW-1:0] sx_w, sy_w;

  always_comb begin
    unique case (cv_w[NCor].quad)
      QuadOne:   begin cc = -c_w[NCor].sy; ss = c_w[NCor].cx; end
      QuadTwo:   begin cc = -c_w[NCor].cx; ss = -c_w[NCor].sy; end
      QuadThree: begin cc = c_w[NCor].sy; ss = -c_w[NCor].cx; end
      default:   begin cc = c_w[NCor].cx; ss = c_w[NCor].sy; end
    endcase
  end

  assign sx_w = (cx_q - sy_q + TermW'(64'sd1 << 29)) >>> 30;
  assign sy_w = (sx_q + cy_q + TermW'(64'sd1 << 29)) >>> 30;

  always_ff @(posedge clk_i) begin
    cx_q <= TermW'(cc * cv_w[NCor].x);
    sy_q <= TermW'(ss * cv_w[NCor].y);
    sx_q <= TermW'(ss * cv_w[NCor].x);
    cy_q <= TermW'(cc * cv_w[NCor].y);
    ox_q <= sx_w;
    oy_q <= sy_w;
    out_x_o <= (ox_q > TermW'(CoordMax)) ? CoordMax :
               (ox_q < TermW'(CoordMin)) ? CoordMin : ox_q[CoordW-1:0];
    out_y_o <= (oy_q > TermW'(CoordMax)) ? CoordMax :
               (oy_q < TermW'(CoordMin)) ? CoordMin : oy_q[CoordW-1:0];
  end

  assign valid_o = vld_q[Lat-1];

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> $past(start_i)) else $error("valid pipe broken");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> rate_q == $past(cfg_data_i)) else $error("rate not written");
`endif

endmodule
